### src/open_addressing_hash_table_unit_macros.svh
// Assertion macros for the hash table unit
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH
`define OAH_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("oah check failed");
`define OAH_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("oah check failed");
`endif

### src/oaht_pkg.sv
//------------------------------------------------------------------------------
// oaht_pkg
// Types and codes shared by the hash table unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package oaht_pkg;
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_FIND   = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_USED  = 2'd1;
	localparam logic [1:0] ST_TOMB  = 2'd2;
	localparam logic [1:0] RES_OK   = 2'd0;
	localparam logic [1:0] RES_MISS = 2'd1;
	localparam logic [1:0] RES_FULL = 2'd2;
	localparam logic REG_TABLE_SIZE = 1'b0;
	localparam logic REG_PROBE_MODE = 1'b1;
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MOD   = 7'b0000010,
		S_CLEAR = 7'b0000100,
		S_ISSUE = 7'b0001000,
		S_CHECK = 7'b0010000,
		S_WRITE = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;
endpackage

### src/open_addressing_hash_table_unit.sv
// Steps: the key modulo (restoring division, one quotient bit per cycle), then
// a read and a check per slot visited, a write step and the result beat. An
// insert into a full table visits one more slot than the table size; only
// one command at a time, the next one taken the cycle after the result beat.
// After reset a clearing pass marks every slot empty; no command is taken
// during it. Configuration writes are taken at any time.
//------------------------------------------------------------------------------
// open_addressing_hash_table_unit
// Closed hash table of keys with insert, find and remove commands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "open_addressing_hash_table_unit_macros.svh"
module open_addressing_hash_table_unit #(
	parameter int SLOTS    = 256,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  slot,
	output logic [8:0]  count
);
	localparam int AW = $clog2(SLOTS);
	localparam int NW = AW + 1;
	localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int CW = $clog2(KW);

	oaht_pkg::state_t state_q;
	logic [8:0]    size_q;
	logic          mode_q;
	logic [NW-1:0] n_q;
	logic [1:0]    cmd_q;
	logic [KW-1:0] key_q;
	logic [NW:0]   rem_q;
	logic [CW-1:0] bit_q;
	logic [AW-1:0] addr_q, clr_q;
	logic [NW-1:0] step_q;
	logic [NW-1:0] cnt_q;
	logic [1:0]    res_q;
	logic [AW-1:0] res_slot_q;

	logic [1:0]    st_mem [SLOTS];
	logic [KW-1:0] key_mem [SLOTS];
	logic [1:0]    st_rd_s1;
	logic [KW-1:0] key_rd_s1;
	logic          we;
	logic [AW-1:0] wa;
	logic [1:0]    wst;

	logic [NW-1:0] n_eff;
	logic [NW:0]   rem_sh;
	logic [NW:0]   sum;
	logic [NW-1:0] nxt_addr;
	logic [NW-1:0] nxt_off;
	logic          hit, is_free, at_home, last;

	always_comb begin
		if (size_q == 9'd0) n_eff = NW'(1);
		else if ({{(NW > 9 ? NW-9 : 0){1'b0}}, size_q} > (NW > 9 ? NW : 9)'(SLOTS))
			n_eff = NW'(SLOTS);
		else n_eff = NW'(size_q);
	end

	assign rem_sh = {rem_q[NW-1:0], key_q[bit_q]};
	assign hit = (st_rd_s1 == oaht_pkg::ST_USED) && (key_rd_s1 == key_q);
	assign is_free = (st_rd_s1 == oaht_pkg::ST_EMPTY) || (st_rd_s1 == oaht_pkg::ST_TOMB);
	assign at_home = (step_q == '0);
	// next offset: linear adds 1, quadratic adds step+1 on inserts only (finds and removes always add 1)
	assign nxt_off = (mode_q && cmd_q == oaht_pkg::CMD_INSERT) ? step_q + NW'(1) : NW'(1);
	assign sum = {1'b0, NW'(addr_q)} + {1'b0, nxt_off};
	always_comb begin
		if (sum >= {1'b0, n_q}) nxt_addr = NW'(sum - {1'b0, n_q});
		else nxt_addr = sum[NW-1:0];
	end
	assign last = (cmd_q == oaht_pkg::CMD_INSERT) ? (step_q == n_q) : (step_q + NW'(1) == n_q);

	always_ff @(posedge clk) begin
		if (we) begin
			st_mem[wa] <= wst;
			if (wst == oaht_pkg::ST_USED) key_mem[wa] <= key_q;
		end
		st_rd_s1 <= st_mem[addr_q];
		key_rd_s1 <= key_mem[addr_q];
	end

	always_comb begin
		we = 1'b0;
		wa = res_slot_q;
		wst = oaht_pkg::ST_USED;
		if (state_q == oaht_pkg::S_CLEAR) begin
			we = 1'b1;
			wa = clr_q;
			wst = oaht_pkg::ST_EMPTY;
		end else if (state_q == oaht_pkg::S_WRITE && res_q == oaht_pkg::RES_OK) begin
			we = (cmd_q == oaht_pkg::CMD_INSERT) || (cmd_q == oaht_pkg::CMD_REMOVE);
			wst = (cmd_q == oaht_pkg::CMD_INSERT) ? oaht_pkg::ST_USED : oaht_pkg::ST_TOMB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaht_pkg::S_CLEAR;
			size_q <= 9'd256;
			mode_q <= 1'b0;
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == oaht_pkg::REG_TABLE_SIZE) size_q <= cfg_data;
				else mode_q <= cfg_data[0];
			end
			unique case (state_q)
				oaht_pkg::S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SLOTS - 1)) state_q <= oaht_pkg::S_IDLE;
				end
				oaht_pkg::S_IDLE: if (in_valid) begin
					cmd_q <= cmd;
					key_q <= key[KW-1:0];
					n_q <= n_eff;
					rem_q <= '0;
					bit_q <= CW'(KW - 1);
					state_q <= oaht_pkg::S_MOD;
				end
				oaht_pkg::S_MOD: begin
					// restoring division, one quotient bit per cycle
					if (rem_sh >= {1'b0, n_q}) rem_q <= rem_sh - {1'b0, n_q};
					else rem_q <= rem_sh;
					bit_q <= bit_q - CW'(1);
					if (bit_q == '0) begin
						if (cmd_q != oaht_pkg::CMD_INSERT && cmd_q != oaht_pkg::CMD_FIND
							&& cmd_q != oaht_pkg::CMD_REMOVE) begin
							res_q <= oaht_pkg::RES_MISS;
							state_q <= oaht_pkg::S_WRITE;
						end else state_q <= oaht_pkg::S_ISSUE;
						addr_q <= AW'((rem_sh >= {1'b0, n_q}) ? rem_sh - {1'b0, n_q} : rem_sh);
						step_q <= '0;
					end
				end
				oaht_pkg::S_ISSUE: state_q <= oaht_pkg::S_CHECK;
				oaht_pkg::S_CHECK: begin
					if (cmd_q == oaht_pkg::CMD_INSERT ? is_free : hit) begin
						res_q <= oaht_pkg::RES_OK;
						res_slot_q <= addr_q;
						state_q <= oaht_pkg::S_WRITE;
					end else if ((cmd_q != oaht_pkg::CMD_INSERT && at_home
						&& st_rd_s1 == oaht_pkg::ST_EMPTY) || last) begin
						res_q <= (cmd_q == oaht_pkg::CMD_INSERT) ?
							oaht_pkg::RES_FULL : oaht_pkg::RES_MISS;
						state_q <= oaht_pkg::S_WRITE;
					end else begin
						step_q <= step_q + NW'(1);
						addr_q <= AW'(nxt_addr);
						state_q <= oaht_pkg::S_ISSUE;
					end
				end
				oaht_pkg::S_WRITE: begin
					if (res_q == oaht_pkg::RES_OK) begin
						if (cmd_q == oaht_pkg::CMD_INSERT) cnt_q <= cnt_q + NW'(1);
						else if (cmd_q == oaht_pkg::CMD_REMOVE && cnt_q != '0)
							cnt_q <= cnt_q - NW'(1);
					end
					state_q <= oaht_pkg::S_OUT;
				end
				oaht_pkg::S_OUT: if (out_ready) state_q <= oaht_pkg::S_IDLE;
				default: state_q <= oaht_pkg::S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == oaht_pkg::S_IDLE);
	assign out_valid = (state_q == oaht_pkg::S_OUT);
	assign status = res_q;
	assign slot = (res_q == oaht_pkg::RES_OK) ? 8'(res_slot_q) : 8'd0;
	assign count = 9'(cnt_q);

	`OAH_ASSERT_IMPL(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`OAH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(res_q))
	`OAH_ASSERT_IMPL(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= NW'(SLOTS))
endmodule
